### rtl/assert_macros.svh
// Assertion macros used by the checker file, sns_checker.sv.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sns_pkg.sv
// Shared types, codes and helpers for the SPI NOR command sequencer.
// No dependencies; used by every rtl module.
package sns_pkg;

  localparam logic [12:0] MAX_LEN    = 13'd4096;
  localparam logic [8:0]  PAGE_BYTES = 9'd256;

  // request function codes
  localparam logic [2:0] FUNC_READ       = 3'd0;
  localparam logic [2:0] FUNC_FAST_READ  = 3'd1;
  localparam logic [2:0] FUNC_ERASE      = 3'd2;
  localparam logic [2:0] FUNC_PROG_ERASE = 3'd3;
  localparam logic [2:0] FUNC_PROG       = 3'd4;

  // flash opcodes
  localparam logic [7:0] OP_READ3  = 8'h03;
  localparam logic [7:0] OP_READ4  = 8'h13;
  localparam logic [7:0] OP_FREAD3 = 8'h0B;
  localparam logic [7:0] OP_FREAD4 = 8'h0C;
  localparam logic [7:0] OP_SE3    = 8'h20;
  localparam logic [7:0] OP_SE4    = 8'h21;
  localparam logic [7:0] OP_PP3    = 8'h02;
  localparam logic [7:0] OP_PP4    = 8'h12;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_WRDI   = 8'h04;

  // post-frame waits in ms
  localparam logic [8:0] DLY_SHORT = 9'd5;
  localparam logic [8:0] DLY_ERASE = 9'd450;

  typedef struct packed {
    logic [2:0]  func;
    logic [23:0] start_page;
    logic [7:0]  page_offset;
    logic [12:0] byte_count;
    logic [15:0] sector_number;
  } req_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [2:0]  addr_bytes;
    logic [31:0] flash_address;
    logic        dummy_bytes;
    logic [8:0]  write_count;
    logic [11:0] data_offset;
    logic [12:0] read_count;
    logic [8:0]  delay_ms;
    logic        last;
  } frame_t;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_FAST_READ,
    JOB_ERASE,
    JOB_PROGRAM
  } job_kind_e;

  // classified request handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    logic        erase_first;
    logic        two_sectors;
    logic [19:0] sector;
    logic [23:0] page;
    logic [7:0]  off;
    logic [12:0] count;
  } job_t;

  function automatic logic [31:0] fit_addr(input logic four, input logic [31:0] a);
    fit_addr = four ? a : {8'd0, a[23:0]};
  endfunction

  function automatic logic [2:0] addr_len(input logic four);
    addr_len = four ? 3'd4 : 3'd3;
  endfunction

endpackage

### rtl/sns_front.sv
// Request front end: clamps the count and classifies one request into a job.
// Depends on sns_pkg.
module sns_front (
  input  sns_pkg::req_t req_i,
  input  logic          accept_i,
  output logic          push_o,
  output sns_pkg::job_t job_o
);

  logic [12:0] count;
  logic [13:0] span;
  logic [24:0] end_page;
  logic        known;

  assign count    = (req_i.byte_count > sns_pkg::MAX_LEN) ? sns_pkg::MAX_LEN
                                                           : req_i.byte_count;
  assign span     = {1'b0, count} + {6'd0, req_i.page_offset} - 14'd1;
  assign end_page = {1'b0, req_i.start_page} + {20'd0, span[12:8]};

  always_comb begin
    job_o             = '0;
    job_o.page        = req_i.start_page;
    job_o.off         = req_i.page_offset;
    job_o.count       = count;
    job_o.sector      = req_i.start_page[23:4];
    job_o.two_sectors = end_page[24:4] != {1'b0, req_i.start_page[23:4]};
    job_o.kind        = sns_pkg::JOB_READ;
    known             = 1'b1;
    case (req_i.func)
      sns_pkg::FUNC_READ:      job_o.kind = sns_pkg::JOB_READ;
      sns_pkg::FUNC_FAST_READ: job_o.kind = sns_pkg::JOB_FAST_READ;
      sns_pkg::FUNC_ERASE: begin
        job_o.kind        = sns_pkg::JOB_ERASE;
        job_o.sector      = {4'd0, req_i.sector_number};
        job_o.two_sectors = 1'b0;
      end
      sns_pkg::FUNC_PROG_ERASE: begin
        job_o.kind        = sns_pkg::JOB_PROGRAM;
        job_o.erase_first = 1'b1;
        known             = count != 13'd0;
      end
      sns_pkg::FUNC_PROG: begin
        job_o.kind = sns_pkg::JOB_PROGRAM;
        known      = count != 13'd0;
      end
      default: known = 1'b0;
    endcase
  end

  // unknown functions and empty programs emit nothing
  assign push_o = accept_i && known;

endmodule

### rtl/sns_queue.sv
// Two-entry job queue between front and back ends.
// Depends on sns_pkg.
module sns_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sns_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output sns_pkg::job_t job_o
);

  logic [1:0]    count_q, count_d;
  sns_pkg::job_t head_q, head_d, tail_q, tail_d;
  logic          do_pop;

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (do_pop && push_i) begin
      if (count_q == 2'd1) begin
        head_d = job_i;
      end else begin
        head_d = tail_q;
        tail_d = job_i;
      end
    end else if (do_pop) begin
      head_d  = tail_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) head_d = job_i;
      else tail_d = job_i;
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= 2'd0;
    else count_q <= count_d;
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign job_o   = head_q;

endmodule

### rtl/sns_back.sv
// Frame sequencer: expands one job into frame words, one per cycle.
// Depends on sns_pkg.
module sns_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            four_byte_i,
  input  logic            job_valid_i,
  input  sns_pkg::job_t   job_i,
  output logic            job_pop_o,
  output logic            rsp_strobe_o,
  output sns_pkg::frame_t rsp_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_ERASE, ST_PROGRAM} state_e;
  typedef enum logic [1:0] {STEP_WREN, STEP_CMD, STEP_WRDI} step_e;

  state_e          state_q, state_d;
  step_e           step_q, step_d, step_nxt;
  logic            fast_q, fast_d, prog_q, prog_d, more_q, more_d;
  logic [19:0]     sector_q, sector_d;
  logic [23:0]     page_q, page_d;
  logic [7:0]      off_q, off_d;
  logic [12:0]     left_q, left_d;
  logic [11:0]     pos_q, pos_d;
  logic            strobe_q, strobe_d;
  sns_pkg::frame_t frame_q, frame_d;

  logic [13:0] room;
  logic [8:0]  n;
  logic        prog_done;
  logic [31:0] rw_addr, se_addr;

  // bytes in this page program
  assign room      = {1'b0, left_q} + {6'd0, off_q};
  assign n         = (room < {5'd0, sns_pkg::PAGE_BYTES}) ? left_q[8:0]
                                                          : sns_pkg::PAGE_BYTES - {1'b0, off_q};
  assign prog_done = left_q == {4'd0, n};
  assign rw_addr   = sns_pkg::fit_addr(four_byte_i, {page_q, off_q});
  assign se_addr   = sns_pkg::fit_addr(four_byte_i, {sector_q, 12'd0});

  always_comb begin
    case (step_q)
      STEP_WREN: step_nxt = STEP_CMD;
      STEP_CMD:  step_nxt = STEP_WRDI;
      default:   step_nxt = STEP_WREN;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    fast_d    = fast_q;
    prog_d    = prog_q;
    more_d    = more_q;
    sector_d  = sector_q;
    page_d    = page_q;
    off_d     = off_q;
    left_d    = left_q;
    pos_d     = pos_q;
    strobe_d  = 1'b0;
    frame_d   = '0;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          page_d    = job_i.page;
          off_d     = job_i.off;
          left_d    = job_i.count;
          pos_d     = 12'd0;
          sector_d  = job_i.sector;
          more_d    = job_i.two_sectors;
          fast_d    = job_i.kind == sns_pkg::JOB_FAST_READ;
          prog_d    = job_i.kind == sns_pkg::JOB_PROGRAM;
          step_d    = STEP_WREN;
          case (job_i.kind)
            sns_pkg::JOB_READ, sns_pkg::JOB_FAST_READ: state_d = ST_READ;
            sns_pkg::JOB_ERASE:                         state_d = ST_ERASE;
            default: state_d = job_i.erase_first ? ST_ERASE : ST_PROGRAM;
          endcase
        end
      end
      ST_READ: begin
        strobe_d              = 1'b1;
        frame_d.opcode        = fast_q ? (four_byte_i ? sns_pkg::OP_FREAD4 : sns_pkg::OP_FREAD3)
                                       : (four_byte_i ? sns_pkg::OP_READ4 : sns_pkg::OP_READ3);
        frame_d.addr_bytes    = sns_pkg::addr_len(four_byte_i);
        frame_d.flash_address = rw_addr;
        frame_d.dummy_bytes   = fast_q;
        frame_d.read_count    = left_q;
        frame_d.last          = 1'b1;
        state_d               = ST_IDLE;
      end
      ST_ERASE: begin
        strobe_d = 1'b1;
        step_d   = step_nxt;
        case (step_q)
          STEP_WREN: begin
            frame_d.opcode   = sns_pkg::OP_WREN;
            frame_d.delay_ms = sns_pkg::DLY_SHORT;
          end
          STEP_CMD: begin
            frame_d.opcode        = four_byte_i ? sns_pkg::OP_SE4 : sns_pkg::OP_SE3;
            frame_d.addr_bytes    = sns_pkg::addr_len(four_byte_i);
            frame_d.flash_address = se_addr;
            frame_d.delay_ms      = sns_pkg::DLY_ERASE;
          end
          default: begin
            frame_d.opcode   = sns_pkg::OP_WRDI;
            frame_d.delay_ms = sns_pkg::DLY_SHORT;
            if (more_q) begin
              more_d   = 1'b0;
              sector_d = sector_q + 20'd1;
            end else if (prog_q) begin
              state_d = ST_PROGRAM;
            end else begin
              frame_d.last = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
      end
      ST_PROGRAM: begin
        strobe_d = 1'b1;
        step_d   = step_nxt;
        case (step_q)
          STEP_WREN: begin
            frame_d.opcode   = sns_pkg::OP_WREN;
            frame_d.delay_ms = sns_pkg::DLY_SHORT;
          end
          STEP_CMD: begin
            frame_d.opcode        = four_byte_i ? sns_pkg::OP_PP4 : sns_pkg::OP_PP3;
            frame_d.addr_bytes    = sns_pkg::addr_len(four_byte_i);
            frame_d.flash_address = rw_addr;
            frame_d.write_count   = n;
            frame_d.data_offset   = pos_q;
            frame_d.delay_ms      = sns_pkg::DLY_SHORT;
          end
          default: begin
            frame_d.opcode   = sns_pkg::OP_WRDI;
            frame_d.delay_ms = sns_pkg::DLY_SHORT;
            page_d           = page_q + 24'd1;
            off_d            = 8'd0;
            left_d           = left_q - {4'd0, n};
            pos_d            = pos_q + {3'd0, n};
            if (prog_done) begin
              frame_d.last = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= STEP_WREN;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fast_q   <= fast_d;
    prog_q   <= prog_d;
    more_q   <= more_d;
    sector_q <= sector_d;
    page_q   <= page_d;
    off_q    <= off_d;
    left_q   <= left_d;
    pos_q    <= pos_d;
    frame_q  <= frame_d;
  end

  assign rsp_strobe_o = strobe_q;
  assign rsp_o        = frame_q;

endmodule

### rtl/spi_nor_command_sequencer.sv
// Top level of the SPI NOR command sequencer.
// Depends on sns_pkg, sns_front, sns_queue and sns_back.
//
// Usage:
//  - Request channel: a request word on req_i is taken at a rising edge with
//    start high and busy low. busy rises only when the two-entry job queue
//    is full, so up to two requests may wait behind the one in progress.
//  - Result channel: each frame word is on rsp_o for exactly one cycle with
//    rsp_strobe_o high; the receiver cannot stall it. The final frame of a
//    request has last set. Unknown functions and empty programs give none.
//  - Config channel: cfg_data_i sets the 4-byte address mode bit when
//    cfg_valid_i is high (cfg_ready_o is tied high). Write only while idle.
//  - Path: from an idle sequencer the first frame passes the job queue entry,
//    the sequencer's load of the job and the frame register to the ports.
//  - Throughput: one frame per cycle while a job runs, with a load state
//    before each job that sends none; a request gives 1 to 57 frames.
//  - Reset (rst_ni low, asynchronous): queue empty, sequencer idle, no
//    strobe, 3-byte addressing.
module spi_nor_command_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sns_pkg::req_t   req_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i,
  output logic            rsp_strobe_o,
  output sns_pkg::frame_t rsp_o
);

  logic          four_byte_q;
  logic          push, pop, job_valid, full;
  sns_pkg::job_t job_in, job_out;

  // address mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) four_byte_q <= 1'b0;
    else if (cfg_valid_i && cfg_ready_o) four_byte_q <= cfg_data_i;
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  sns_front u_front (
    .req_i    (req_i),
    .accept_i (start && !busy),
    .push_o   (push),
    .job_o    (job_in)
  );

  sns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .full_o  (full),
    .job_o   (job_out)
  );

  // frame sequencer; the user must keep the mode bit stable while any job is in flight (not enforced here)
  sns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .four_byte_i  (four_byte_q),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_pop_o    (pop),
    .rsp_strobe_o (rsp_strobe_o),
    .rsp_o        (rsp_o)
  );

endmodule

### rtl/sns_checker.sv
// Port-level checker for the SPI NOR command sequencer, bound to the top.
// Depends on sns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sns_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_strobe_o,
  input sns_pkg::frame_t rsp_o
);

  logic is_read, is_erase;
  logic mid_frame, wren_frame, cmd_frame, erase_frame, wrdi_frame, read_frame;

  assign is_read  = rsp_o.opcode == sns_pkg::OP_READ3 || rsp_o.opcode == sns_pkg::OP_READ4 ||
                    rsp_o.opcode == sns_pkg::OP_FREAD3 || rsp_o.opcode == sns_pkg::OP_FREAD4;
  assign is_erase = rsp_o.opcode == sns_pkg::OP_SE3 || rsp_o.opcode == sns_pkg::OP_SE4;

  assign mid_frame   = rsp_strobe_o && !rsp_o.last;
  assign wren_frame  = rsp_strobe_o && rsp_o.opcode == sns_pkg::OP_WREN;
  assign cmd_frame   = rsp_strobe_o && rsp_o.opcode != sns_pkg::OP_WREN;
  assign erase_frame = rsp_strobe_o && is_erase;
  assign wrdi_frame  = rsp_strobe_o && rsp_o.opcode == sns_pkg::OP_WRDI;
  assign read_frame  = rsp_strobe_o && is_read;

  // frames of one request come out back to back
  `ASSERT_NEXT(a_frames_contiguous, clk_i, rst_ni, mid_frame, rsp_strobe_o, "gap in request")

  // write enable is never the final frame and is followed by a command
  `ASSERT_NEXT(a_wren_followed, clk_i, rst_ni, wren_frame, cmd_frame, "wren without command")

  // every sector erase is closed by write disable
  `ASSERT_NEXT(a_erase_closed, clk_i, rst_ni, erase_frame, wrdi_frame, "erase not closed")

  // a read is a request of its own single frame
  `ASSERT_SAME(a_read_single, clk_i, rst_ni, read_frame, rsp_o.last, "read frame not last")

endmodule

bind spi_nor_command_sequencer sns_checker u_sns_checker (.*);

### tb/sv/testbench.sv
// Self-checking bench for spi_nor_command_sequencer: flash requests in, frame words out.
// Depends on sns_pkg and the sequencer RTL. The expected frames come from a predictor
// kept inside this file.
`timescale 1ns / 100ps

module testbench;

  // Function codes past the last defined one. The sequencer must drop these silently.
  localparam logic [2:0] FUNC_NONE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_NONE_LAST  = 3'd7;

  // flash geometry as the predictor sees it
  localparam int unsigned PAGE_SIZE   = 256;
  localparam int unsigned SECTOR_SIZE = 16;       // pages per 4 KiB sector
  localparam int unsigned PAGE_MASK   = 32'hFF_FFFF;

  localparam int DRAIN_LIMIT   = 5000;  // cycles allowed for the frame queue to empty
  localparam int SETTLE_CYCLES = 20;    // covers queued requests that give no frames
  localparam int REPORT_LIMIT  = 30;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  sns_pkg::req_t   req_i;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic            cfg_data_i;
  logic            rsp_strobe_o;
  sns_pkg::frame_t rsp_o;

  spi_nor_command_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .rsp_strobe_o(rsp_strobe_o),
    .rsp_o       (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state. The only register is the address mode. It changes only while
  // the sequencer is idle, so each request is planned with the mode in force when
  // it is accepted.
  logic            addr4;
  sns_pkg::frame_t frames_due[$];
  sns_pkg::frame_t due_frame;

  int errors;
  int requests_sent;
  int frames_seen;
  int idle_pct;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] mode_addr(input logic [31:0] a);
    return addr4 ? a : {8'h00, a[23:0]};
  endfunction

  // Byte address of a page. Page numbers wrap at 24 bits.
  function automatic int unsigned page_base(input int unsigned page);
    return mode_addr((page & PAGE_MASK) * PAGE_SIZE);
  endfunction

  function automatic int unsigned addr_width();
    return addr4 ? 32'd4 : 32'd3;
  endfunction

  task automatic push_frame(input int unsigned op, input int unsigned nab,
                            input int unsigned addr, input int unsigned dummy,
                            input int unsigned wc, input int unsigned doff,
                            input int unsigned rc, input int unsigned dly);
    sns_pkg::frame_t f;
    f.opcode        = op[7:0];
    f.addr_bytes    = nab[2:0];
    f.flash_address = addr;
    f.dummy_bytes   = dummy[0];
    f.write_count   = wc[8:0];
    f.data_offset   = doff[11:0];
    f.read_count    = rc[12:0];
    f.delay_ms      = dly[8:0];
    f.last          = 1'b0;
    frames_due.push_back(f);
  endtask

  task automatic push_wren();
    push_frame(32'(sns_pkg::OP_WREN), 0, 0, 0, 0, 0, 0, 32'(sns_pkg::DLY_SHORT));
  endtask

  task automatic push_wrdi();
    push_frame(32'(sns_pkg::OP_WRDI), 0, 0, 0, 0, 0, 0, 32'(sns_pkg::DLY_SHORT));
  endtask

  // One sector erase, bracketed by write enable and write disable.
  task automatic push_erase(input int unsigned addr);
    push_wren();
    push_frame(32'(addr4 ? sns_pkg::OP_SE4 : sns_pkg::OP_SE3), addr_width(),
               mode_addr(addr), 0, 0, 0, 0, 32'(sns_pkg::DLY_ERASE));
    push_wrdi();
  endtask

  // Queue every frame that one accepted request should produce.
  task automatic plan_frames(input sns_pkg::req_t r);
    int unsigned cnt, page, off, end_page, sec, pos, left, n;
    int          n_prior;
    n_prior = frames_due.size();
    // clamp oversized counts
    cnt  = (r.byte_count > sns_pkg::MAX_LEN) ? 32'(sns_pkg::MAX_LEN) : 32'(r.byte_count);
    page = 32'(r.start_page);
    off  = 32'(r.page_offset);
    case (r.func)
      sns_pkg::FUNC_READ: begin
        push_frame(32'(addr4 ? sns_pkg::OP_READ4 : sns_pkg::OP_READ3), addr_width(),
                   mode_addr(page_base(page) + off), 0, 0, 0, cnt, 0);
      end
      sns_pkg::FUNC_FAST_READ: begin
        push_frame(32'(addr4 ? sns_pkg::OP_FREAD4 : sns_pkg::OP_FREAD3), addr_width(),
                   mode_addr(page_base(page) + off), 1, 0, 0, cnt, 0);
      end
      sns_pkg::FUNC_ERASE: begin
        push_erase(32'(r.sector_number) * SECTOR_SIZE * PAGE_SIZE);
      end
      sns_pkg::FUNC_PROG_ERASE, sns_pkg::FUNC_PROG: begin
        if (cnt != 0) begin
          // The end page is not masked, so the sector walk runs past the 24-bit
          // wrap. Only the erase address wraps.
          end_page = page + (cnt + off - 1) / PAGE_SIZE;
          if (r.func == sns_pkg::FUNC_PROG_ERASE) begin
            for (sec = page / SECTOR_SIZE; sec <= end_page / SECTOR_SIZE; sec++)
              push_erase(((sec * SECTOR_SIZE) & PAGE_MASK) * PAGE_SIZE);
          end
          pos  = 0;
          left = cnt;
          while (left > 0) begin
            n = (left + off < PAGE_SIZE) ? left : PAGE_SIZE - off;
            push_wren();
            push_frame(32'(addr4 ? sns_pkg::OP_PP4 : sns_pkg::OP_PP3), addr_width(),
                       mode_addr(page_base(page) + off), 0, n, pos, 0,
                       32'(sns_pkg::DLY_SHORT));
            push_wrdi();
            page++;
            off  = 0;
            left -= n;
            pos  += n;
          end
        end
      end
      default: ;  // unknown function: nothing on the wire
    endcase
    if (frames_due.size() > n_prior)
      frames_due[frames_due.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Frame checker: every strobe must match the oldest expected frame.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: frame %0d %s mismatch: expected %0h, actual %0h",
                 $time, frames_seen, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_strobe_o) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected frame: expected none, actual %h", $time, rsp_o);
      end else begin
        due_frame = frames_due.pop_front();
        check_field("opcode",        32'(due_frame.opcode),      32'(rsp_o.opcode));
        check_field("addr_bytes",    32'(due_frame.addr_bytes),  32'(rsp_o.addr_bytes));
        check_field("flash_address", due_frame.flash_address,    rsp_o.flash_address);
        check_field("dummy_bytes",   32'(due_frame.dummy_bytes), 32'(rsp_o.dummy_bytes));
        check_field("write_count",   32'(due_frame.write_count), 32'(rsp_o.write_count));
        check_field("data_offset",   32'(due_frame.data_offset), 32'(rsp_o.data_offset));
        check_field("read_count",    32'(due_frame.read_count),  32'(rsp_o.read_count));
        check_field("delay_ms",      32'(due_frame.delay_ms),    32'(rsp_o.delay_ms));
        check_field("last",          32'(due_frame.last),        32'(rsp_o.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request and config drivers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------

  function automatic sns_pkg::req_t make_req(input logic [2:0] func,
                                             input logic [23:0] page,
                                             input logic [7:0] off,
                                             input logic [12:0] cnt,
                                             input logic [15:0] sector);
    sns_pkg::req_t r;
    r.func          = func;
    r.start_page    = page;
    r.page_offset   = off;
    r.byte_count    = cnt;
    r.sector_number = sector;
    return r;
  endfunction

  // Send one request word and plan its frames at the accepting edge. start stays
  // high afterward, so back-to-back words arrive with no gap. Idle cycles are added
  // at random, each one a falling edge with start low.
  task automatic send_request(input sns_pkg::req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    plan_frames(r);
    requests_sent++;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= {$urandom, $urandom};   // noise while start is low
    end
  endtask

  // Stop sending, wait for every expected frame, then let queued no-frame requests
  // drain out of the sequencer.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (frames_due.size() != 0) begin
      errors++;
      $display("%0t: %0d frames expected but never seen", $time, frames_due.size());
      frames_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic four);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= four;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    addr4 = four;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly defined functions with small counts. Some requests land near the top
  // page, use oversized or zero counts, or carry an unknown function.
  function automatic sns_pkg::req_t random_request();
    sns_pkg::req_t r;
    int unsigned   pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 6) r.func = 3'($urandom_range(FUNC_NONE_LAST, FUNC_NONE_FIRST));
    else          r.func = 3'($urandom_range(sns_pkg::FUNC_PROG, sns_pkg::FUNC_READ));
    if ($urandom_range(99) < 15)
      r.start_page = 24'(32'hFF_FFFF - $urandom_range(40));
    pick = $urandom_range(99);
    if (pick < 5)       r.byte_count = '0;
    else if (pick < 13) r.byte_count = 13'($urandom_range(8191, 4097));
    else if (pick < 18) r.byte_count = sns_pkg::MAX_LEN;
    else if (pick < 23) r.byte_count = 13'(PAGE_SIZE);
    else                r.byte_count = 13'($urandom_range(700, 1));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 3-byte mode straight out of reset. Covers field extremes, address truncation,
  // count clamping, zero counts, sector crossing and page wrap.
  task automatic test_directed_3byte();
    idle_pct = 0;
    send_request(make_req(sns_pkg::FUNC_READ,       24'h00_0000, 8'h00, 13'd1,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_READ,       24'hFF_FFFF, 8'hFF, 13'd4096, 16'hFFFF));
    send_request(make_req(sns_pkg::FUNC_FAST_READ,  24'h12_3456, 8'h7F, 13'd0,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_READ,       24'h00_0100, 8'h01, 13'd8191, 16'h0000));
    send_request(make_req(sns_pkg::FUNC_ERASE,      24'h00_0000, 8'h00, 13'd0,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_ERASE,      24'hFF_FFFF, 8'hFF, 13'd8191, 16'hFFFF));
    send_request(make_req(sns_pkg::FUNC_PROG_ERASE, 24'h00_000F, 8'h10, 13'd512,  16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG,       24'h00_0000, 8'h00, 13'd256,  16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG,       24'h00_0005, 8'hFF, 13'd2,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG,       24'h00_0040, 8'h20, 13'd0,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG_ERASE, 24'h00_0040, 8'h20, 13'd0,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG_ERASE, 24'hFF_FFFF, 8'hFF, 13'd4096, 16'h0000));
    for (int f = FUNC_NONE_FIRST; f <= FUNC_NONE_LAST; f++)
      send_request(make_req(f[2:0], 24'hFF_FFFF, 8'hFF, 13'd4096, 16'hFFFF));
    wait_drained();
  endtask

  // Corner cases with 4-byte opcodes and full 32-bit addresses.
  task automatic test_directed_4byte();
    write_mode(1'b1);
    idle_pct = 0;
    send_request(make_req(sns_pkg::FUNC_READ,       24'hFF_FFFF, 8'hFF, 13'd1,    16'h0000));
    send_request(make_req(sns_pkg::FUNC_FAST_READ,  24'h80_0000, 8'h00, 13'd4097, 16'h0000));
    send_request(make_req(sns_pkg::FUNC_ERASE,      24'h00_0000, 8'h00, 13'd1,    16'hFFFF));
    send_request(make_req(sns_pkg::FUNC_PROG_ERASE, 24'hFF_FFF0, 8'h00, 13'd4096, 16'h0000));
    send_request(make_req(sns_pkg::FUNC_PROG,       24'hAB_CDEF, 8'h80, 13'd300,  16'h0000));
    send_request(make_req(sns_pkg::FUNC_FAST_READ,  24'h00_0001, 8'h01, 13'd0,    16'h0000));
    wait_drained();
  endtask

  task automatic test_random_phase(input int n_items, input int pct, input logic four);
    write_mode(four);
    idle_pct = pct;
    repeat (n_items) send_request(random_request());
    wait_drained();
  endtask

  // Back-to-back words, then a full stop until every frame is out, then more.
  task automatic test_pause_until_drained();
    write_mode(1'b1);
    idle_pct = 0;
    repeat (20) send_request(random_request());
    wait_drained();
    repeat (20) send_request(random_request());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    errors        = 0;
    requests_sent = 0;
    frames_seen   = 0;
    idle_pct      = 0;
    addr4         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_3byte();
    test_directed_4byte();
    test_random_phase(45, 0,  1'b0);
    test_random_phase(45, 75, 1'b1);
    test_random_phase(45, 10, 1'b0);
    test_pause_until_drained();

    if (frames_due.size() != 0) begin
      errors++;
      $display("%0t: %0d frames still expected at end of run", $time, frames_due.size());
    end
    $display("Ran %0d requests and checked %0d frames in 3- and 4-byte address mode,",
             requests_sent, frames_seen);
    $display("with sender idle rates of 0, 10 and 75 percent and one full drain pause.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run: about 200 requests of up to 57
  // frames each, plus idle gaps and drain waits.
  initial begin
    #(8_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sns_pkg.sv
rtl/sns_front.sv
rtl/sns_queue.sv
rtl/sns_back.sv
rtl/spi_nor_command_sequencer.sv
rtl/sns_checker.sv
tb/sv/testbench.sv
